// ----- hw/rtl/prq_pkg.sv -----
// Shared constants, codes and types of the priority ready queue.
`default_nettype none

package prq_pkg;

  // Default sizes
  localparam int THREAD_COUNT_DEF = 64;
  localparam int LEVEL_COUNT_DEF  = 32;

  // Port field widths
  localparam int REQ_W  = 2;
  localparam int ID_W   = 6;
  localparam int PRIO_W = 5;
  localparam int STAT_W = 2;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] stat_t;

  // Request codes
  localparam req_t REQ_ENQUEUE = 2'd0;
  localparam req_t REQ_DEQUEUE = 2'd1;
  localparam req_t REQ_REMOVE  = 2'd2;

  // Result status codes
  localparam stat_t STAT_OK         = 2'd0;
  localparam stat_t STAT_EMPTY      = 2'd1;
  localparam stat_t STAT_NOT_QUEUED = 2'd2;
  localparam stat_t STAT_ALREADY    = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/priority_ready_queue.sv -----
// Bitmap priority ready queue with per-level linked FIFOs held in two memories.
`default_nettype none

// One FIFO of thread ids per priority level; the highest non-empty level is
// served first. Items are accepted when start is high and busy is low; each
// item gives exactly one result, shown for one cycle with out_valid high, in
// the cycle after its last step. The receiver cannot stall. A request decided
// at once (id out of range, empty queue on dequeue, remove at an empty level,
// unused code) gives its result from the idle state; enqueue reads the
// thread's entry, then links the thread to its level's tail when the level
// already holds threads; dequeue reads the level's head, then pops it; remove
// checks the thread's entry and the level's head, ends there when the thread
// is not queued or heads its level, and otherwise walks the list, reading one
// entry per step, until it ends without the thread or unlinks it. The pace is
// set by the thread memory, which holds the queued bit and next link of each
// thread and has one read and one write port: every list step waits for its
// registered read. After reset a clearing pass runs through the thread memory
// with busy high.
module priority_ready_queue #(
  parameter int THREAD_COUNT = prq_pkg::THREAD_COUNT_DEF,
  parameter int LEVEL_COUNT  = prq_pkg::LEVEL_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire prq_pkg::req_t               in_req_type,
  input  wire logic [prq_pkg::ID_W-1:0]    in_thread_id,
  input  wire logic [prq_pkg::PRIO_W-1:0]  in_thread_prio,
  output logic                             out_valid,
  output prq_pkg::stat_t                   out_status,
  output logic [prq_pkg::ID_W-1:0]         out_thread,
  output logic [prq_pkg::PRIO_W-1:0]       out_prio,
  output logic                             out_any_ready
);

  localparam int TW   = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int LW   = TW + 1;
  localparam int LVW  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int IDW  = prq_pkg::ID_W;
  localparam int PRW  = prq_pkg::PRIO_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(THREAD_COUNT);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ENQ      = 4'd2;
  localparam logic [3:0] S_ENQ_LINK = 4'd3;
  localparam logic [3:0] S_DEQ_HEAD = 4'd4;
  localparam logic [3:0] S_DEQ_POP  = 4'd5;
  localparam logic [3:0] S_REM_CHK  = 4'd6;
  localparam logic [3:0] S_REM_WALK = 4'd7;
  localparam logic [3:0] S_REM_DROP = 4'd8;

  // Thread memory entry: {queued, next link}; level memory entry: {head, tail}
  logic [LW:0]     tmem [THREAD_COUNT];
  logic [2*TW-1:0] lmem [LEVEL_COUNT];

  logic [LW:0]     tm_rdata_r;
  logic [2*TW-1:0] lm_rdata_r;
  logic [TW-1:0]   tm_raddr, tm_waddr;
  logic [LW:0]     tm_wdata;
  logic            tm_we;
  logic [LVW-1:0]  lm_raddr, lm_waddr;
  logic [2*TW-1:0] lm_wdata;
  logic            lm_we;

  logic [3:0]             state_r, state_nxt;
  logic [TW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [LEVEL_COUNT-1:0] mask_r, mask_nxt;
  logic [TW-1:0]          tid_r, tid_nxt;
  logic [LVW-1:0]         lvl_r, lvl_nxt;
  logic [TW-1:0]          head_r, head_nxt;
  logic [TW-1:0]          tail_r, tail_nxt;
  logic [TW-1:0]          prev_r, prev_nxt;
  logic [LW-1:0]          tlink_r, tlink_nxt;

  logic                   out_valid_r, out_valid_nxt;
  prq_pkg::stat_t         out_status_r, out_status_nxt;
  logic [IDW-1:0]         out_thread_r, out_thread_nxt;
  logic [PRW-1:0]         out_prio_r, out_prio_nxt;
  logic                   out_any_ready_r, out_any_ready_nxt;

  logic                   id_ok;
  logic [TW-1:0]          tid_in;
  logic [LVW-1:0]         lvl_in;
  logic [LVW-1:0]         top_lvl;
  logic [TW-1:0]          rd_head, rd_tail;
  logic [LW-1:0]          rd_link;

  assign id_ok   = int'(in_thread_id) < THREAD_COUNT;
  assign tid_in  = TW'(in_thread_id);
  assign lvl_in  = (int'(in_thread_prio) >= LEVEL_COUNT) ? LVW'(LEVEL_COUNT - 1)
                                                         : LVW'(in_thread_prio);
  assign rd_head = lm_rdata_r[2*TW-1:TW];
  assign rd_tail = lm_rdata_r[TW-1:0];
  assign rd_link = tm_rdata_r[LW-1:0];

  // Highest non-empty level
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (mask_r[i]) begin
        top_lvl = LVW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tmem[tm_waddr] <= tm_wdata;
    end
    tm_rdata_r <= tmem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[lm_waddr] <= lm_wdata;
    end
    lm_rdata_r <= lmem[lm_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    mask_nxt       = mask_r;
    tid_nxt        = tid_r;
    lvl_nxt        = lvl_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    prev_nxt       = prev_r;
    tlink_nxt      = tlink_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_thread_nxt = out_thread_r;
    out_prio_nxt   = out_prio_r;
    tm_raddr       = tid_r;
    tm_we          = 1'b0;
    tm_waddr       = tid_r;
    tm_wdata       = {1'b0, NULL_LINK};
    lm_raddr       = lvl_r;
    lm_we          = 1'b0;
    lm_waddr       = lvl_r;
    lm_wdata       = {head_r, tail_r};

    case (state_r)
      S_CLEAR: begin
        tm_we    = 1'b1;
        tm_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == TW'(THREAD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        tm_raddr = tid_in;
        lm_raddr = (in_req_type == prq_pkg::REQ_DEQUEUE) ? top_lvl : lvl_in;
        if (start) begin
          tid_nxt        = tid_in;
          lvl_nxt        = (in_req_type == prq_pkg::REQ_DEQUEUE) ? top_lvl : lvl_in;
          out_thread_nxt = '0;
          out_prio_nxt   = '0;
          out_status_nxt = prq_pkg::STAT_OK;
          case (in_req_type)
            prq_pkg::REQ_ENQUEUE: begin
              if (!id_ok) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = prq_pkg::STAT_NOT_QUEUED;
              end else begin
                state_nxt = S_ENQ;
              end
            end
            prq_pkg::REQ_DEQUEUE: begin
              if (mask_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = prq_pkg::STAT_EMPTY;
              end else begin
                state_nxt = S_DEQ_HEAD;
              end
            end
            prq_pkg::REQ_REMOVE: begin
              if (!id_ok || !mask_r[lvl_in]) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = prq_pkg::STAT_NOT_QUEUED;
              end else begin
                state_nxt = S_REM_CHK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_ENQ: begin
        if (tm_rdata_r[LW]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = prq_pkg::STAT_ALREADY;
          state_nxt      = S_IDLE;
        end else begin
          tm_we    = 1'b1;
          tm_wdata = {1'b1, NULL_LINK};
          lm_we    = 1'b1;
          mask_nxt[lvl_r] = 1'b1;
          if (mask_r[lvl_r]) begin
            // append behind the current tail
            lm_wdata  = {rd_head, tid_r};
            tail_nxt  = rd_tail;
            state_nxt = S_ENQ_LINK;
          end else begin
            lm_wdata      = {tid_r, tid_r};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_ENQ_LINK: begin
        tm_we         = 1'b1;
        tm_waddr      = tail_r;
        tm_wdata      = {1'b1, LW'(tid_r)};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_DEQ_HEAD: begin
        head_nxt  = rd_head;
        tail_nxt  = rd_tail;
        tm_raddr  = rd_head;
        state_nxt = S_DEQ_POP;
      end

      S_DEQ_POP: begin
        lm_we    = 1'b1;
        lm_wdata = {TW'(rd_link), tail_r};
        if (rd_link == NULL_LINK) begin
          mask_nxt[lvl_r] = 1'b0;
        end
        tm_we          = 1'b1;
        tm_waddr       = head_r;
        out_valid_nxt  = 1'b1;
        out_thread_nxt = IDW'(head_r);
        out_prio_nxt   = PRW'(lvl_r);
        state_nxt      = S_IDLE;
      end

      S_REM_CHK: begin
        tlink_nxt = rd_link;
        head_nxt  = rd_head;
        tail_nxt  = rd_tail;
        if (!tm_rdata_r[LW]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = prq_pkg::STAT_NOT_QUEUED;
          state_nxt      = S_IDLE;
        end else if (rd_head == tid_r) begin
          // thread heads its level: advance the head
          lm_we    = 1'b1;
          lm_wdata = {TW'(rd_link), rd_tail};
          if (rd_link == NULL_LINK) begin
            mask_nxt[lvl_r] = 1'b0;
          end
          tm_we         = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          prev_nxt  = rd_head;
          tm_raddr  = rd_head;
          state_nxt = S_REM_WALK;
        end
      end

      S_REM_WALK: begin
        if (rd_link == NULL_LINK) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = prq_pkg::STAT_NOT_QUEUED;
          state_nxt      = S_IDLE;
        end else if (rd_link == LW'(tid_r)) begin
          // bypass the thread and pull the tail back if it was last
          tm_we    = 1'b1;
          tm_waddr = prev_r;
          tm_wdata = {1'b1, tlink_r};
          if (tail_r == tid_r) begin
            lm_we    = 1'b1;
            lm_wdata = {head_r, prev_r};
          end
          state_nxt = S_REM_DROP;
        end else begin
          prev_nxt = TW'(rd_link);
          tm_raddr = TW'(rd_link);
        end
      end

      S_REM_DROP: begin
        tm_we         = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_any_ready_nxt = |mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tid_r           <= tid_nxt;
    lvl_r           <= lvl_nxt;
    head_r          <= head_nxt;
    tail_r          <= tail_nxt;
    prev_r          <= prev_nxt;
    tlink_r         <= tlink_nxt;
    out_status_r    <= out_status_nxt;
    out_thread_r    <= out_thread_nxt;
    out_prio_r      <= out_prio_nxt;
    out_any_ready_r <= out_any_ready_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_thread    = out_thread_r;
  assign out_prio      = out_prio_r;
  assign out_any_ready = out_any_ready_r;

  a_empty_means_none_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == prq_pkg::STAT_EMPTY) |-> !out_any_ready_r)
    else $error("empty dequeue reported with threads still ready");

  a_walk_on_live_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM_WALK) |-> mask_r[lvl_r])
    else $error("list walk on a level marked empty");

  a_pop_on_live_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_POP) |-> mask_r[lvl_r])
    else $error("dequeue pop on a level marked empty");

  a_no_result_from_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result strobe during the clearing pass");

endmodule

`default_nettype wire

// ----- verif/prq_checker.sv -----
// Checker for the priority ready queue: predicts every result and compares it with the block.
module prq_checker
  import prq_pkg::*;
#(
  parameter int THREADS = THREAD_COUNT_DEF,
  parameter int LEVELS  = LEVEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  req_t               in_req_type,
  input  logic [ID_W-1:0]    in_thread_id,
  input  logic [PRIO_W-1:0]  in_thread_prio,
  input  logic               out_valid,
  input  stat_t              out_status,
  input  logic [ID_W-1:0]    out_thread,
  input  logic [PRIO_W-1:0]  out_prio,
  input  logic               out_any_ready,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    stat_t              status;
    logic [ID_W-1:0]    thread;
    logic [PRIO_W-1:0]  prio;
    logic               any;
  } sched_result_t;

  // Bit ID_W set marks the end of a list
  localparam logic [ID_W:0] NO_NEXT = (ID_W + 1)'(THREADS);

  logic [LEVELS-1:0] ready_mask;
  logic [ID_W:0]     first_thr [LEVELS];
  logic [ID_W:0]     last_thr  [LEVELS];
  logic [ID_W:0]     succ      [THREADS];
  logic              in_queue  [THREADS];

  sched_result_t due_results [$];
  int errs    = 0;
  int checked = 0;

  initial begin
    fail_count      <= 0;
    pending         <= 0;
    results_checked <= 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errs++;
  endtask

  task automatic clear_queue();
    ready_mask = '0;
    for (int i = 0; i < LEVELS; i++) begin
      first_thr[i] = '0;
      last_thr[i]  = '0;
    end
    for (int i = 0; i < THREADS; i++) begin
      succ[i]     = NO_NEXT;
      in_queue[i] = 1'b0;
    end
  endtask

  // Apply one request to the shadow queue and work out the result it gives
  task automatic apply_request(input req_t req, input logic [ID_W-1:0] tid,
                               input logic [PRIO_W-1:0] lvl, output sched_result_t res);
    logic [ID_W:0] h, prv, cur;
    int steps;
    bit found;
    res = '0;
    res.status = STAT_OK;
    case (req)
      REQ_ENQUEUE: begin
        if (in_queue[tid]) begin
          res.status = STAT_ALREADY;
        end else begin
          succ[tid] = NO_NEXT;
          if (!ready_mask[lvl]) first_thr[lvl] = {1'b0, tid};
          else if (!last_thr[lvl][ID_W]) succ[last_thr[lvl][ID_W-1:0]] = {1'b0, tid};
          last_thr[lvl]   = {1'b0, tid};
          ready_mask[lvl] = 1'b1;
          in_queue[tid]   = 1'b1;
        end
      end
      REQ_DEQUEUE: begin
        found = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
          if (!found && ready_mask[l]) begin
            h = first_thr[l];
            if (h[ID_W]) begin
              ready_mask[l] = 1'b0;
            end else begin
              first_thr[l] = succ[h[ID_W-1:0]];
              if (succ[h[ID_W-1:0]][ID_W]) ready_mask[l] = 1'b0;
              succ[h[ID_W-1:0]]     = NO_NEXT;
              in_queue[h[ID_W-1:0]] = 1'b0;
              res.thread = h[ID_W-1:0];
              res.prio   = PRIO_W'(l);
              found      = 1'b1;
            end
          end
        end
        if (!found) res.status = STAT_EMPTY;
      end
      REQ_REMOVE: begin
        if (!in_queue[tid] || !ready_mask[lvl]) begin
          res.status = STAT_NOT_QUEUED;
        end else if (first_thr[lvl] == {1'b0, tid}) begin
          first_thr[lvl] = succ[tid];
          if (succ[tid][ID_W]) ready_mask[lvl] = 1'b0;
          succ[tid]     = NO_NEXT;
          in_queue[tid] = 1'b0;
        end else begin
          // Walk the level's list to find the predecessor
          prv   = first_thr[lvl];
          cur   = prv[ID_W] ? NO_NEXT : succ[prv[ID_W-1:0]];
          steps = 0;
          while (steps < THREADS && !cur[ID_W] && cur[ID_W-1:0] != tid) begin
            prv = cur;
            cur = succ[cur[ID_W-1:0]];
            steps++;
          end
          if (cur != {1'b0, tid} || prv[ID_W]) begin
            res.status = STAT_NOT_QUEUED;
          end else begin
            succ[prv[ID_W-1:0]] = succ[tid];
            if (last_thr[lvl] == {1'b0, tid}) last_thr[lvl] = prv;
            succ[tid]     = NO_NEXT;
            in_queue[tid] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.any = |ready_mask;
  endtask

  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst_n) begin
      clear_queue();
      due_results.delete();
    end else begin
      // Retire the result first: an item taken on the same edge is younger
      if (out_valid) begin
        got.status = out_status;
        got.thread = out_thread;
        got.prio   = out_prio;
        got.any    = out_any_ready;
        checked++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting", checked));
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      checked, got.status, want.status));
          if (got.thread !== want.thread)
            report_mismatch($sformatf("result %0d thread %0d, expected %0d",
                                      checked, got.thread, want.thread));
          if (got.prio !== want.prio)
            report_mismatch($sformatf("result %0d prio %0d, expected %0d",
                                      checked, got.prio, want.prio));
          if (got.any !== want.any)
            report_mismatch($sformatf("result %0d any_ready %0d, expected %0d",
                                      checked, got.any, want.any));
        end
      end
      if (start && !busy) begin
        apply_request(in_req_type, in_thread_id, in_thread_prio, want);
        due_results.push_back(want);
      end
    end
    pending         <= due_results.size();
    fail_count      <= errs;
    results_checked <= checked;
  end

endmodule

// ----- verif/priority_ready_queue_test.sv -----
// Testbench top for the priority ready queue: clock, reset, request stimulus and verdict.
module priority_ready_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prq_pkg::*;

  // Request code the block treats as a no-op
  localparam req_t REQ_SPARE = 2'd3;
  localparam int   IDLE_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  req_t               in_req_type = REQ_ENQUEUE;
  logic [ID_W-1:0]    in_thread_id = '0;
  logic [PRIO_W-1:0]  in_thread_prio = '0;
  logic               out_valid;
  stat_t              out_status;
  logic [ID_W-1:0]    out_thread;
  logic [PRIO_W-1:0]  out_prio;
  logic               out_any_ready;

  int fail_count, pending, results_checked;
  int req_count [4] = '{0, 0, 0, 0};
  bit idle_on = 1'b0;
  int idle_cycles = 0;
  logic [PRIO_W-1:0] prio_of [64];

  priority_ready_queue i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_thread_id   (in_thread_id),
    .in_thread_prio (in_thread_prio),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_thread     (out_thread),
    .out_prio       (out_prio),
    .out_any_ready  (out_any_ready)
  );

  prq_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_thread_id    (in_thread_id),
    .in_thread_prio  (in_thread_prio),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_thread      (out_thread),
    .out_prio        (out_prio),
    .out_any_ready   (out_any_ready),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stop the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one request, hold it until taken, then idle for a while if enabled
  task automatic send_item(input req_t req, input logic [ID_W-1:0] tid,
                           input logic [PRIO_W-1:0] lvl);
    int gap, roll;
    start          <= 1'b1;
    in_req_type    <= req;
    in_thread_id   <= tid;
    in_thread_prio <= lvl;
    do @(posedge clk); while (busy !== 1'b0);
    req_count[req]++;
    gap = 0;
    if (idle_on) begin
      roll = $urandom_range(99);
      if (roll < 60)      gap = 0;
      else if (roll < 90) gap = $urandom_range(3, 1);
      else if (roll < 98) gap = $urandom_range(12, 4);
      else                gap = $urandom_range(60, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int enq_pct, roll;
    bit narrow;
    req_t req;
    logic [ID_W-1:0] tid;
    logic [PRIO_W-1:0] lvl;

    for (int i = 0; i < 64; i++) prio_of[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, absent thread, spare code, FIFO order, list repair
    idle_on = 1'b0;
    send_item(REQ_DEQUEUE, 6'd0, 5'd0);
    send_item(REQ_REMOVE, 6'd5, 5'd3);
    send_item(REQ_SPARE, 6'd63, 5'd31);
    send_item(REQ_ENQUEUE, 6'd0, 5'd0);
    send_item(REQ_ENQUEUE, 6'd63, 5'd31);
    send_item(REQ_ENQUEUE, 6'd21, 5'd31);
    send_item(REQ_ENQUEUE, 6'd42, 5'd31);
    send_item(REQ_ENQUEUE, 6'd63, 5'd0);
    send_item(REQ_REMOVE, 6'd42, 5'd0);
    send_item(REQ_REMOVE, 6'd21, 5'd5);
    send_item(REQ_REMOVE, 6'd21, 5'd31);
    send_item(REQ_REMOVE, 6'd42, 5'd31);
    send_item(REQ_ENQUEUE, 6'd10, 5'd31);
    send_item(REQ_DEQUEUE, 6'd63, 5'd31);
    send_item(REQ_DEQUEUE, 6'd0, 5'd0);
    send_item(REQ_REMOVE, 6'd0, 5'd0);
    send_item(REQ_ENQUEUE, 6'd7, 5'd0);
    send_item(REQ_SPARE, 6'd0, 5'd0);
    send_item(REQ_DEQUEUE, 6'd63, 5'd31);
    send_item(REQ_DEQUEUE, 6'd0, 5'd0);
    send_item(REQ_REMOVE, 6'd7, 5'd0);
    wait_drained();

    // Random: fill-heavy, balanced and drain-heavy phases, some on few levels
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph % 3 != 0);
      narrow  = ph[0];
      case (ph % 3)
        0:       enq_pct = 70;
        1:       enq_pct = 40;
        default: enq_pct = 25;
      endcase
      for (int n = 0; n < 240; n++) begin
        roll = $urandom_range(99);
        tid  = ID_W'($urandom());
        if (narrow) lvl = ($urandom_range(9) == 0) ? 5'd31 : PRIO_W'($urandom_range(2));
        else        lvl = PRIO_W'($urandom());
        if (roll < enq_pct) begin
          req = REQ_ENQUEUE;
          prio_of[tid] = lvl;
        end else if (roll < enq_pct + (100 - enq_pct) / 2) begin
          req = REQ_DEQUEUE;
        end else if (roll < 97) begin
          req = REQ_REMOVE;
          // Mostly aim at the level the thread was last queued on
          if ($urandom_range(3) != 0) lvl = prio_of[tid];
        end else begin
          req = REQ_SPARE;
        end
        send_item(req, tid, lvl);
        if ($urandom_range(99) == 0) wait_drained();
      end
      wait_drained();
    end

    // Allow for the slowest request, a remove walking a full list
    repeat (80) @(posedge clk);

    $display("Covered %0d requests: %0d enqueue, %0d dequeue, %0d remove, %0d spare code.",
             req_count[REQ_ENQUEUE] + req_count[REQ_DEQUEUE] + req_count[REQ_REMOVE]
             + req_count[REQ_SPARE], req_count[REQ_ENQUEUE], req_count[REQ_DEQUEUE],
             req_count[REQ_REMOVE], req_count[REQ_SPARE]);
    $display("Checked %0d results over single-level and spread-out lists, with and without gaps.",
             results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
